>>> rtl/core/ertd_pkg.sv
`timescale 1ns / 1ps

package ertd_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 16;
    localparam int FRAC_W    = 8;
    localparam int DELAY_W   = 12;
    localparam int BUF_AW    = 12;
    localparam int BUF_DEPTH = 1 << BUF_AW;
    localparam int MAX_TAPS  = 32;
    localparam int TAP_AW    = $clog2(MAX_TAPS);
    localparam int CNT_W     = 6;
    localparam int OUT_SHIFT = SAMPLE_W - 1;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int MIX_W     = DIFF_W + FRAC_W + 1;
    localparam int INTERP_W  = SAMPLE_W + FRAC_W;
    localparam int PROD_W    = INTERP_W + GAIN_W;
    localparam int ACC_W     = 56;
    localparam int SHIFT_W   = ACC_W - OUT_SHIFT;
    localparam int ENTRY_W   = DELAY_W + FRAC_W + GAIN_W;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(18);

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    typedef struct packed {
        logic start;
        logic issue;
        logic cap;
        logic cap_ok;
        logic mix;
        logic mix_ok;
        logic mac;
    } t_dp_ctrl;

endpackage

>>> rtl/core/ertd_ram.sv
`timescale 1ns / 1ps

module ertd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ertd_datapath.sv
`timescale 1ns / 1ps

module ertd_datapath (
    input  logic                                   i_clk,
    input  ertd_pkg::t_dp_ctrl                     i_ctrl,
    input  logic signed [ertd_pkg::SAMPLE_W-1:0]   i_x,
    input  logic signed [ertd_pkg::SAMPLE_W-1:0]   i_q,
    input  logic        [ertd_pkg::FRAC_W-1:0]     i_frac,
    input  logic signed [ertd_pkg::GAIN_W-1:0]     i_gain,
    output logic signed [ertd_pkg::SAMPLE_W-1:0]   o_y
);

    import ertd_pkg::*;

    logic signed [ACC_W-1:0]    r_acc;
    logic        [FRAC_W-1:0]   r_f;
    logic signed [GAIN_W-1:0]   r_g0;
    logic signed [GAIN_W-1:0]   r_g1;
    logic signed [SAMPLE_W-1:0] r_s0;
    logic signed [INTERP_W-1:0] r_interp;

    logic signed [SAMPLE_W-1:0]           w_s1;
    logic signed [DIFF_W-1:0]             w_diff;
    logic signed [MIX_W-1:0]              w_prod;
    logic signed [MIX_W-1:0]              w_mix;
    logic signed [PROD_W-1:0]             w_mac;
    logic signed [ACC_W-1:0]              w_rnd;
    logic signed [SHIFT_W-1:0]            w_sh;
    logic        [SHIFT_W-SAMPLE_W:0]     w_upper;

    // interp = 256*s0 + f*(s1 - s0)
    assign w_s1   = i_ctrl.mix_ok ? i_q : '0;
    assign w_diff = DIFF_W'(w_s1) - DIFF_W'(r_s0);
    assign w_prod = $signed({1'b0, r_f}) * w_diff;
    assign w_mix  = (MIX_W'(r_s0) <<< FRAC_W) + w_prod;
    assign w_mac  = r_interp * r_g1;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.issue) begin
            r_f  <= i_frac;
            r_g0 <= i_gain;
        end
        if (i_ctrl.cap) begin
            r_s0 <= i_ctrl.cap_ok ? i_q : '0;
        end
        if (i_ctrl.mix) begin
            r_interp <= w_mix[INTERP_W-1:0];
            r_g1     <= r_g0;
        end
        if (i_ctrl.start) begin
            r_acc <= ACC_W'(i_x) <<< OUT_SHIFT;
        end else if (i_ctrl.mac) begin
            r_acc <= r_acc + ACC_W'(w_mac);
        end
    end

    // round half up, then saturate
    assign w_rnd   = r_acc + (ACC_W'(1) <<< (OUT_SHIFT - 1));
    assign w_sh    = w_rnd[ACC_W-1:OUT_SHIFT];
    assign w_upper = w_sh[SHIFT_W-1:SAMPLE_W-1];

    always_comb begin
        if (&w_upper || ~|w_upper) begin
            o_y = w_sh[SAMPLE_W-1:0];
        end else begin
            o_y = {w_sh[SHIFT_W-1], {(SAMPLE_W-1){~w_sh[SHIFT_W-1]}}};
        end
    end

endmodule

>>> rtl/core/early_reflection_tap_delay_top.sv
`timescale 1ns / 1ps

// Multi-tap early-reflection generator. A sample beat (func 0) returns one beat:
// the input plus, for each of the first min(active_tap_count, 32) taps, gain
// times the linearly interpolated delayed sample, rounded and saturated to
// 24 bits. A load beat (func 1) writes one tap entry and returns nothing.
// Each tap needs two reads of the delay memory, which has a single read
// port, and the multiply-accumulate pipeline drains before the result is
// presented. Delay memory slots not yet written since reset read as zero
// through a fill flag, so no clearing pass is needed after reset. Taps that
// are summed must have been loaded first. The tap count resets to 18.
module early_reflection_tap_delay_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic        [ertd_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_func,
    input  logic signed [ertd_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic        [ertd_pkg::TAP_AW-1:0]    i_tap_index,
    input  logic        [ertd_pkg::DELAY_W-1:0]   i_tap_whole_delay,
    input  logic        [ertd_pkg::FRAC_W-1:0]    i_tap_fraction,
    input  logic signed [ertd_pkg::GAIN_W-1:0]    i_tap_gain,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ertd_pkg::SAMPLE_W-1:0]  o_sample_out
);

    import ertd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                 r_state;
    logic                       r_phase;
    logic [TAP_AW-1:0]          r_idx;
    logic [CNT_W-1:0]           r_left;
    logic [CNT_W-1:0]           r_active;
    logic [BUF_AW-1:0]          r_wp;
    logic                       r_wrap;
    logic [BUF_AW-1:0]          r_rd_m1;
    logic                       r_ok0;
    logic                       r_ok1;
    logic                       r_mix_v;
    logic                       r_mac_v;
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic                       w_in_acc;
    logic                       w_load;
    logic                       w_start;
    logic                       w_fire;
    logic [CNT_W-1:0]           w_taps;
    logic [TAP_AW-1:0]          w_tap_raddr;
    logic [ENTRY_W-1:0]         w_entry;
    logic [DELAY_W-1:0]         w_q_delay;
    logic [FRAC_W-1:0]          w_q_frac;
    logic signed [GAIN_W-1:0]   w_q_gain;
    logic [BUF_AW-1:0]          w_rd;
    logic [BUF_AW-1:0]          w_buf_raddr;
    logic signed [SAMPLE_W-1:0] w_buf_q;
    logic signed [SAMPLE_W-1:0] w_y;
    t_dp_ctrl                   w_ctrl;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_load     = w_in_acc && (i_func == FUNC_LOAD);
    assign w_start    = w_in_acc && (i_func == FUNC_SAMPLE);
    assign w_taps     = (r_active > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : r_active;
    assign w_fire     = (r_state == S_FIN) && !r_mix_v && !r_mac_v
                        && (!r_out_valid || !i_out_stall);

    // tap table, prefetch next entry during the second read of a tap
    assign w_tap_raddr = r_phase ? (r_idx + TAP_AW'(1)) : r_idx;

    ertd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (i_tap_index),
        .i_wdata ({i_tap_whole_delay, i_tap_fraction, i_tap_gain}),
        .i_raddr (w_tap_raddr),
        .o_rdata (w_entry)
    );

    assign w_q_delay = w_entry[ENTRY_W-1 -: DELAY_W];
    assign w_q_frac  = w_entry[GAIN_W +: FRAC_W];
    assign w_q_gain  = w_entry[GAIN_W-1:0];

    assign w_rd        = r_wp - BUF_AW'(w_q_delay);
    assign w_buf_raddr = r_phase ? r_rd_m1 : w_rd;

    ertd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUF_DEPTH)
    ) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire),
        .i_waddr (r_wp),
        .i_wdata (r_x),
        .i_raddr (w_buf_raddr),
        .o_rdata (w_buf_q)
    );

    always_comb begin
        w_ctrl        = '0;
        w_ctrl.start  = w_start;
        w_ctrl.issue  = (r_state == S_RUN) && !r_phase;
        w_ctrl.cap    = (r_state == S_RUN) && r_phase;
        w_ctrl.cap_ok = r_ok0;
        w_ctrl.mix    = r_mix_v;
        w_ctrl.mix_ok = r_ok1;
        w_ctrl.mac    = r_mac_v;
    end

    ertd_datapath u_datapath (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_x    (i_sample_in),
        .i_q    (w_buf_q),
        .i_frac (w_q_frac),
        .i_gain (w_q_gain),
        .o_y    (w_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_idx       <= '0;
            r_left      <= '0;
            r_active    <= ACTIVE_RESET;
            r_wp        <= '0;
            r_wrap      <= 1'b0;
            r_mix_v     <= 1'b0;
            r_mac_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            r_mix_v <= (r_state == S_RUN) && r_phase;
            r_mac_v <= r_mix_v;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_idx   <= '0;
                        r_phase <= 1'b0;
                        r_left  <= w_taps;
                        r_state <= (w_taps == '0) ? S_FIN : S_RUN;
                    end
                end
                S_RUN: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        r_left  <= r_left - CNT_W'(1);
                        if (r_left == CNT_W'(1)) begin
                            r_idx   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_idx <= r_idx + TAP_AW'(1);
                        end
                    end
                end
                S_FIN: begin
                    if (w_fire) begin
                        r_wp    <= r_wp + BUF_AW'(1);
                        r_state <= S_IDLE;
                        if (r_wp == '1) begin
                            r_wrap <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_x <= i_sample_in;
        end
        if ((r_state == S_RUN) && !r_phase) begin
            r_rd_m1 <= w_rd - BUF_AW'(1);
            r_ok0   <= r_wrap || (w_rd < r_wp);
        end
        if ((r_state == S_RUN) && r_phase) begin
            r_ok1 <= r_wrap || (r_rd_m1 < r_wp);
        end
        if (w_fire) begin
            r_out_data <= w_y;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

    a_fire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("result beat not presented after finish");

    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_wp == $past(r_wp) + BUF_AW'(1)))
        else $error("write position did not advance by one");

    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_mix_v && !r_mac_v))
        else $error("mac pipeline busy while idle");

    a_mac_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mac_v |-> $past(r_mix_v))
        else $error("accumulate without preceding interpolation");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ertd_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 2 * MAX_TAPS + 16;
    localparam int SQUEEZE_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [GAIN_W-1:0]   GAIN_MAX   = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic signed [GAIN_W-1:0]   GAIN_MIN   = {1'b1, {(GAIN_W-1){1'b0}}};
    localparam logic        [DELAY_W-1:0]  DELAY_MAX  = '1;
    localparam logic        [FRAC_W-1:0]   FRAC_MAX   = '1;

    typedef struct {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample;
        logic        [TAP_AW-1:0]   idx;
        logic        [DELAY_W-1:0]  delay;
        logic        [FRAC_W-1:0]   frac;
        logic signed [GAIN_W-1:0]   gain;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] typed_out;
    } t_echo_beat;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic        [CNT_W-1:0]    i_cfg_wdata;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_func;
    logic signed [SAMPLE_W-1:0] i_sample_in;
    logic        [TAP_AW-1:0]   i_tap_index;
    logic        [DELAY_W-1:0]  i_tap_whole_delay;
    logic        [FRAC_W-1:0]   i_tap_fraction;
    logic signed [GAIN_W-1:0]   i_tap_gain;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_sample_out;

    early_reflection_tap_delay_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_sample_in       (i_sample_in),
        .i_tap_index       (i_tap_index),
        .i_tap_whole_delay (i_tap_whole_delay),
        .i_tap_fraction    (i_tap_fraction),
        .i_tap_gain        (i_tap_gain),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sample_out      (o_sample_out)
    );

    // echo model state
    logic signed [SAMPLE_W-1:0] echo_mem [0:BUF_DEPTH-1];
    logic        [BUF_AW-1:0]   echo_wr_pos;
    logic        [DELAY_W-1:0]  echo_delay [0:MAX_TAPS-1];
    logic        [FRAC_W-1:0]   echo_frac  [0:MAX_TAPS-1];
    logic signed [GAIN_W-1:0]   echo_gain  [0:MAX_TAPS-1];
    logic        [CNT_W-1:0]    echo_tap_count;

    logic signed [SAMPLE_W-1:0] echo_expect_q [$];
    int                         mismatch_count;
    int                         in_idle_pct;
    int                         out_idle_pct;
    logic                       squeeze_req;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic signed [SAMPLE_W-1:0] mix_reflections(
        input logic signed [SAMPLE_W-1:0] x
    );
        longint            acc;
        longint            interp;
        longint            y;
        int                taps;
        logic [BUF_AW-1:0] rd;
        logic [BUF_AW-1:0] rp;
        acc  = longint'(x) * (longint'(1) << OUT_SHIFT);
        taps = (echo_tap_count > MAX_TAPS) ? MAX_TAPS : int'(echo_tap_count);
        for (int t = 0; t < taps; t++) begin
            rd = echo_wr_pos - echo_delay[t];
            rp = rd - 1'b1;
            interp = ((longint'(1) << FRAC_W) - longint'(echo_frac[t])) * longint'(echo_mem[rd])
                   + longint'(echo_frac[t]) * longint'(echo_mem[rp]);
            acc += interp * longint'(echo_gain[t]);
        end
        acc += longint'(1) << (OUT_SHIFT - 1);
        y = acc >>> OUT_SHIFT;
        if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
        if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
        return SAMPLE_W'(y);
    endfunction

    function automatic void apply_beat(input t_echo_beat b);
        logic signed [SAMPLE_W-1:0] mixed;
        if (b.func == FUNC_LOAD) begin
            echo_delay[b.idx] = b.delay;
            echo_frac[b.idx]  = b.frac;
            echo_gain[b.idx]  = b.gain;
        end else begin
            mixed = mix_reflections(b.sample);
            echo_expect_q.push_back(b.typed ? b.typed_out : mixed);
            echo_mem[echo_wr_pos] = b.sample;
            echo_wr_pos  = echo_wr_pos + 1'b1;
        end
    endfunction

    function automatic t_echo_beat sample_beat(
        input logic signed [SAMPLE_W-1:0] x,
        input logic                       typed,
        input logic signed [SAMPLE_W-1:0] typed_out
    );
        t_echo_beat b;
        b.func      = FUNC_SAMPLE;
        b.sample    = x;
        b.idx       = TAP_AW'($urandom);
        b.delay     = DELAY_W'($urandom);
        b.frac      = FRAC_W'($urandom);
        b.gain      = GAIN_W'($urandom);
        b.typed     = typed;
        b.typed_out = typed_out;
        return b;
    endfunction

    function automatic t_echo_beat load_beat(
        input logic        [TAP_AW-1:0]  idx,
        input logic        [DELAY_W-1:0] d,
        input logic        [FRAC_W-1:0]  f,
        input logic signed [GAIN_W-1:0]  g
    );
        t_echo_beat b;
        b.func      = FUNC_LOAD;
        b.sample    = SAMPLE_W'($urandom);
        b.idx       = idx;
        b.delay     = d;
        b.frac      = f;
        b.gain      = g;
        b.typed     = 1'b0;
        b.typed_out = '0;
        return b;
    endfunction

    function automatic t_echo_beat random_beat(input int load_pct);
        logic signed [SAMPLE_W-1:0] x;
        logic        [DELAY_W-1:0]  d;
        logic        [FRAC_W-1:0]   f;
        logic signed [GAIN_W-1:0]   g;
        if ($urandom_range(99) < load_pct) begin
            case ($urandom_range(7))
                0:       d = '0;
                1:       d = DELAY_MAX;
                2:       d = DELAY_W'($urandom_range(8, 1));
                default: d = DELAY_W'($urandom);
            endcase
            case ($urandom_range(7))
                0:       f = '0;
                1:       f = FRAC_MAX;
                default: f = FRAC_W'($urandom);
            endcase
            case ($urandom_range(7))
                0:       g = GAIN_MAX;
                1:       g = GAIN_MIN;
                default: g = GAIN_W'($urandom);
            endcase
            return load_beat(TAP_AW'($urandom_range(MAX_TAPS - 1)), d, f, g);
        end
        case ($urandom_range(9))
            0:       x = SAMPLE_MAX;
            1:       x = SAMPLE_MIN;
            2:       x = '0;
            3:       x = -1;
            default: x = SAMPLE_W'($urandom);
        endcase
        return sample_beat(x, 1'b0, '0);
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(input t_echo_beat b);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_func            = b.func;
        i_sample_in       = b.sample;
        i_tap_index       = b.idx;
        i_tap_whole_delay = b.delay;
        i_tap_fraction    = b.frac;
        i_tap_gain        = b.gain;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_beat(b);
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        i_in_valid = 1'b0;
        while (echo_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_tap_count(input logic [CNT_W-1:0] v);
        settle_block();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(posedge i_clk);
        echo_tap_count = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_phase(
        input logic [CNT_W-1:0] taps,
        input int               items,
        input int               load_pct,
        input logic             squeeze
    );
        set_tap_count(taps);
        if (squeeze) squeeze_req = 1'b1;
        repeat (items) send_beat(random_beat(load_pct));
    endtask

    // receiver side
    initial begin
        int   hold_left;
        logic squeeze_taken;
        hold_left     = 0;
        squeeze_taken = 1'b0;
        i_out_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left   = hold_left - 1;
                i_out_stall = 1'b1;
            end else if (squeeze_req && !squeeze_taken) begin
                squeeze_taken = 1'b1;
                hold_left     = SQUEEZE_CYCLES - 1;
                i_out_stall   = 1'b1;
            end else begin
                i_out_stall = ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : out_check
        logic signed [SAMPLE_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (echo_expect_q.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected output beat: sample_out %0d", o_sample_out);
            end else begin
                want = echo_expect_q.pop_front();
                if (o_sample_out !== want) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("sample_out mismatch: expected %0d, got %0d",
                                 want, o_sample_out);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_echo_beat dir_tab [$];
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        i_in_valid        = 1'b0;
        i_func            = FUNC_SAMPLE;
        i_sample_in       = '0;
        i_tap_index       = '0;
        i_tap_whole_delay = '0;
        i_tap_fraction    = '0;
        i_tap_gain        = '0;
        mismatch_count    = 0;
        in_idle_pct       = 23;
        out_idle_pct      = 59;
        squeeze_req       = 1'b0;
        for (int i = 0; i < BUF_DEPTH; i++) echo_mem[i] = '0;
        for (int i = 0; i < MAX_TAPS; i++) begin
            echo_delay[i] = '0;
            echo_frac[i]  = '0;
            echo_gain[i]  = '0;
        end
        echo_wr_pos    = '0;
        echo_tap_count = ACTIVE_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // every tap loaded before anything is summed, delays long enough that
        // the first 64 samples only see the cleared store
        for (int t = 0; t < MAX_TAPS; t++)
            send_beat(load_beat(TAP_AW'(t), DELAY_W'($urandom_range(DELAY_MAX, 64)),
                                FRAC_W'($urandom), GAIN_W'($urandom)));

        dir_tab.push_back(sample_beat(SAMPLE_MAX, 1'b1, SAMPLE_MAX));
        dir_tab.push_back(sample_beat(SAMPLE_MIN, 1'b1, SAMPLE_MIN));
        dir_tab.push_back(sample_beat('0, 1'b1, '0));
        dir_tab.push_back(load_beat(0, 1, '0, GAIN_MAX));
        dir_tab.push_back(load_beat(1, 2, FRAC_MAX, GAIN_MIN));
        dir_tab.push_back(load_beat(2, '0, 128, 16384));
        dir_tab.push_back(load_beat(3, DELAY_MAX, 1, -1));
        dir_tab.push_back(sample_beat(SAMPLE_MAX, 1'b0, '0));
        dir_tab.push_back(sample_beat(SAMPLE_MAX, 1'b0, '0));
        dir_tab.push_back(sample_beat(SAMPLE_MAX, 1'b0, '0));
        dir_tab.push_back(sample_beat(SAMPLE_MIN, 1'b0, '0));
        dir_tab.push_back(sample_beat(SAMPLE_MIN, 1'b0, '0));
        dir_tab.push_back(sample_beat(1, 1'b0, '0));
        dir_tab.push_back(sample_beat(-1, 1'b0, '0));
        dir_tab.push_back(sample_beat(12345, 1'b0, '0));
        dir_tab.push_back(load_beat(TAP_AW'(MAX_TAPS - 1), 3, 64, GAIN_MAX));
        dir_tab.push_back(load_beat(17, DELAY_MAX, FRAC_MAX, GAIN_MIN));
        dir_tab.push_back(sample_beat(-4194304, 1'b0, '0));
        dir_tab.push_back(sample_beat(4194303, 1'b0, '0));
        dir_tab.push_back(sample_beat('0, 1'b0, '0));
        dir_tab.push_back(load_beat(0, 1, FRAC_MAX, '0));
        dir_tab.push_back(sample_beat(SAMPLE_MAX, 1'b0, '0));
        dir_tab.push_back(sample_beat('0, 1'b0, '0));
        foreach (dir_tab[i]) send_beat(dir_tab[i]);

        run_phase(6'd63, 250, 15, 1'b0);
        run_phase(6'd0, 150, 15, 1'b0);

        in_idle_pct  = 59;
        out_idle_pct = 23;
        run_phase(6'd32, 250, 15, 1'b0);
        run_phase(6'd33, 150, 15, 1'b0);

        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_phase(CNT_W'($urandom_range(MAX_TAPS - 1, 2)), 250, 15, 1'b1);

        // short tap list, mostly sample beats
        set_tap_count(6'd1);
        repeat (150) send_beat(random_beat(3));

        run_phase(ACTIVE_RESET, 150, 15, 1'b0);
        settle_block();

        if (mismatch_count == 0 && echo_expect_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
